// ===== rtl/neighbor_colonization_select_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the colonization select block
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_COLONIZATION_SELECT_TOP_MACROS_SVH
`define NEIGHBOR_COLONIZATION_SELECT_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define NCS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NCS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ncs_pkg.sv =====
// ----------------------------------------------------------------------------
// ncs_pkg
// Types and constants of the neighbor colonization select block.
// ----------------------------------------------------------------------------
package ncs_pkg;

   localparam int PROB_BITS   = 16;
   localparam int PROB_W      = PROB_BITS + 1;
   localparam int MAX_SPECIES = 8;
   localparam int SPEC_BITS   = 3;
   localparam int COUNT_BITS  = 4;
   localparam int HAB_BITS    = 8;
   localparam int ADDR_BITS   = HAB_BITS + SPEC_BITS;
   localparam int DEPTH       = 1 << ADDR_BITS;
   localparam int W_BITS      = PROB_W + COUNT_BITS;
   localparam int SUM_BITS    = W_BITS + SPEC_BITS - 1;
   localparam int MUL_A_BITS  = PROB_W;
   localparam int MUL_B_BITS  = SUM_BITS;
   localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;

   localparam logic [PROB_W-1:0] ONE_Q = PROB_W'(1) << PROB_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MULT,
      ST_NEXT,
      ST_DECIDE,
      ST_ACC,
      ST_RHS,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WRITE,
      OP_START,
      OP_READ,
      OP_LOAD,
      OP_MULT,
      OP_NEXT,
      OP_DECIDE,
      OP_ACC,
      OP_RHS,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic c_zero;
      logic cnt_last;
      logic s_last;
      logic skip;
      logic hit;
   } status_type;

endpackage

// ===== rtl/ncs_req_if.sv =====
// ----------------------------------------------------------------------------
// ncs_req_if
// Request channel: table writes and colonize requests.
// ----------------------------------------------------------------------------
interface ncs_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  habitat;
   logic [2:0]  species_index;
   logic [16:0] probability;
   logic [31:0] neighbor_counts;
   logic [15:0] rand_draw;

   modport source (output valid, req_type, habitat, species_index, probability,
                   neighbor_counts, rand_draw, input ready);
   modport sink   (input valid, req_type, habitat, species_index, probability,
                   neighbor_counts, rand_draw, output ready);
endinterface

// ===== rtl/ncs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ncs_rsp_if
// Response channel: the chosen colonizer.
// ----------------------------------------------------------------------------
interface ncs_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] colonizer;

   modport source (output valid, colonizer, input ready);
   modport sink   (input valid, colonizer, output ready);
endinterface

// ===== rtl/ncs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ncs_ctrl
// Sequencer: steps the datapath through table reads, power multiplies and
// the cumulative compare, and owns the response valid.
// ----------------------------------------------------------------------------
`include "neighbor_colonization_select_top_macros.svh"

module ncs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ncs_pkg::cmd_type    cmd,
   input  ncs_pkg::status_type status
);

   ncs_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = ncs_pkg::OP_NOP;
      cmd.out_load = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ncs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_type) begin
                  cmd.op = ncs_pkg::OP_WRITE;
               end else begin
                  cmd.op   = ncs_pkg::OP_START;
                  state_in = status.n_zero ? ncs_pkg::ST_DECIDE : ncs_pkg::ST_READ;
               end
            end
         end
         ncs_pkg::ST_READ: begin
            cmd.op   = ncs_pkg::OP_READ;
            state_in = ncs_pkg::ST_LOAD;
         end
         ncs_pkg::ST_LOAD: begin
            cmd.op = ncs_pkg::OP_LOAD;
            if (!status.c_zero)     state_in = ncs_pkg::ST_MULT;
            else if (status.s_last) state_in = ncs_pkg::ST_DECIDE;
            else                    state_in = ncs_pkg::ST_NEXT;
         end
         ncs_pkg::ST_MULT: begin
            cmd.op = ncs_pkg::OP_MULT;
            if (status.cnt_last)
               state_in = status.s_last ? ncs_pkg::ST_DECIDE : ncs_pkg::ST_NEXT;
         end
         ncs_pkg::ST_NEXT: begin
            cmd.op   = ncs_pkg::OP_NEXT;
            state_in = ncs_pkg::ST_READ;
         end
         ncs_pkg::ST_DECIDE: begin
            cmd.op   = ncs_pkg::OP_DECIDE;
            state_in = status.skip ? ncs_pkg::ST_FINISH : ncs_pkg::ST_ACC;
         end
         ncs_pkg::ST_ACC: begin
            cmd.op   = ncs_pkg::OP_ACC;
            state_in = ncs_pkg::ST_RHS;
         end
         ncs_pkg::ST_RHS: begin
            cmd.op   = ncs_pkg::OP_RHS;
            state_in = ncs_pkg::ST_CHECK;
         end
         ncs_pkg::ST_CHECK: begin
            cmd.op = ncs_pkg::OP_CHECK;
            if (status.hit || status.s_last) state_in = ncs_pkg::ST_FINISH;
            else                             state_in = ncs_pkg::ST_ACC;
         end
         ncs_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ncs_pkg::ST_IDLE;
            end
         end
         default: state_in = ncs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load)              rsp_valid_in = 1'b1;
   end

   assign rsp_valid = rsp_valid_ff;

   `NCS_ASSERT_IMP(a_no_overwrite, cmd.out_load, (!rsp_valid_ff || rsp_ready), "response overwritten")
   `NCS_ASSERT_NXT(a_load_shows, cmd.out_load, rsp_valid_ff, "loaded response not shown")
   `NCS_ASSERT_NXT(a_acc_to_rhs, (state_ff == ncs_pkg::ST_ACC), (state_ff == ncs_pkg::ST_RHS), "prefix not multiplied")

endmodule

// ===== rtl/ncs_dp.sv =====
// ----------------------------------------------------------------------------
// ncs_dp
// Datapath: probability memory, shared 17x23 multiplier, no-colonization
// product, weight registers and the cross-multiplied compare.
// ----------------------------------------------------------------------------
module ncs_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [3:0]          csr_wdata,
   input  logic [7:0]          req_habitat,
   input  logic [2:0]          req_species_index,
   input  logic [16:0]         req_probability,
   input  logic [31:0]         req_neighbor_counts,
   input  logic [15:0]         req_rand_draw,
   input  ncs_pkg::cmd_type    cmd,
   output ncs_pkg::status_type status,
   output logic [3:0]          rsp_colonizer
);

   logic [ncs_pkg::PROB_W-1:0]   prob_mem [ncs_pkg::DEPTH];
   logic [ncs_pkg::PROB_W-1:0]   rdata_ff;
   logic [3:0]                   species_ff;
   logic [3:0]                   n_ff;
   logic [ncs_pkg::HAB_BITS-1:0] habitat_ff;
   logic [31:0]                  counts_ff;
   logic [15:0]                  draw_ff;
   logic [ncs_pkg::SPEC_BITS-1:0] s_ff;
   logic [ncs_pkg::COUNT_BITS-1:0] cnt_ff;
   logic [ncs_pkg::PROB_W-1:0]   none_ff;
   logic [ncs_pkg::PROB_W-1:0]   q_ff;
   logic [ncs_pkg::W_BITS-1:0]   w_ff [ncs_pkg::MAX_SPECIES];
   logic [ncs_pkg::SUM_BITS-1:0] sum_ff;
   logic [ncs_pkg::SUM_BITS-1:0] prefix_ff;
   logic [ncs_pkg::PROD_BITS-1:0] lhs_ff;
   logic [ncs_pkg::PROD_BITS-1:0] prod_ff;
   logic [3:0]                   result_ff;
   logic [3:0]                   colonizer_ff;

   logic [ncs_pkg::PROB_W-1:0]     wr_prob;
   logic [ncs_pkg::PROB_W-1:0]     p_sat;
   logic [ncs_pkg::COUNT_BITS-1:0] c_cur;
   logic [ncs_pkg::W_BITS-1:0]     w_cur;
   logic [ncs_pkg::MUL_A_BITS-1:0] mul_a;
   logic [ncs_pkg::MUL_B_BITS-1:0] mul_b;
   logic [ncs_pkg::PROD_BITS-1:0]  prod;
   logic [3:0]                     s_plus;

   assign wr_prob = (req_probability > ncs_pkg::ONE_Q) ? ncs_pkg::ONE_Q : req_probability;
   assign p_sat   = (rdata_ff > ncs_pkg::ONE_Q) ? ncs_pkg::ONE_Q : rdata_ff;
   assign c_cur   = counts_ff[s_ff*ncs_pkg::COUNT_BITS +: ncs_pkg::COUNT_BITS];
   assign w_cur   = ncs_pkg::W_BITS'(p_sat) * ncs_pkg::W_BITS'(c_cur);
   assign s_plus  = {1'b0, s_ff} + 4'd1;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         ncs_pkg::OP_MULT: begin
            mul_a = none_ff;
            mul_b = ncs_pkg::MUL_B_BITS'(q_ff);
         end
         ncs_pkg::OP_DECIDE: begin
            mul_a = ncs_pkg::PROB_W'({1'b0, draw_ff}) - none_ff;
            mul_b = sum_ff;
         end
         ncs_pkg::OP_RHS: begin
            mul_a = ncs_pkg::ONE_Q - none_ff;
            mul_b = prefix_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = ncs_pkg::PROD_BITS'(mul_a) * ncs_pkg::PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) species_ff <= 4'd8;
      else if (csr_we) species_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ncs_pkg::OP_WRITE)
         prob_mem[{req_habitat, req_species_index}] <= wr_prob;
      if (cmd.op == ncs_pkg::OP_READ)
         rdata_ff <= prob_mem[{habitat_ff, s_ff}];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ncs_pkg::OP_START: begin
            habitat_ff <= req_habitat;
            counts_ff  <= req_neighbor_counts;
            draw_ff    <= req_rand_draw;
            none_ff    <= ncs_pkg::ONE_Q;
            sum_ff     <= '0;
            s_ff       <= '0;
            n_ff       <= (species_ff > 4'd8) ? 4'd8 : species_ff;
         end
         ncs_pkg::OP_LOAD: begin
            w_ff[s_ff] <= w_cur;
            sum_ff     <= sum_ff + ncs_pkg::SUM_BITS'(w_cur);
            q_ff       <= ncs_pkg::ONE_Q - p_sat;
            cnt_ff     <= c_cur;
         end
         ncs_pkg::OP_MULT: begin
            // truncate back to Q1.16 after every multiply
            none_ff <= prod[ncs_pkg::PROB_BITS +: ncs_pkg::PROB_W];
            cnt_ff  <= cnt_ff - 1'b1;
         end
         ncs_pkg::OP_NEXT: s_ff <= s_ff + 1'b1;
         ncs_pkg::OP_DECIDE: begin
            lhs_ff    <= prod;
            s_ff      <= '0;
            prefix_ff <= '0;
            result_ff <= '0;
         end
         ncs_pkg::OP_ACC: prefix_ff <= prefix_ff + ncs_pkg::SUM_BITS'(w_ff[s_ff]);
         ncs_pkg::OP_RHS: prod_ff <= prod;
         ncs_pkg::OP_CHECK: begin
            if (status.hit) result_ff <= s_plus;
            else            s_ff      <= s_ff + 1'b1;
         end
         default: ;
      endcase
      if (cmd.out_load) colonizer_ff <= result_ff;
   end

   assign status.n_zero   = (species_ff == 4'd0);
   assign status.c_zero   = (c_cur == '0);
   assign status.cnt_last = (cnt_ff == ncs_pkg::COUNT_BITS'(1));
   assign status.s_last   = (s_plus == n_ff);
   assign status.skip     = ({1'b0, draw_ff} < none_ff) || (sum_ff == '0);
   assign status.hit      = (lhs_ff < prod_ff);

   assign rsp_colonizer = colonizer_ff;

endmodule

// ===== rtl/neighbor_colonization_select_top.sv =====
// Sequence: a table write is taken in the idle state; a colonize request reads
//   and loads each species in use, multiplies once per neighbor, then decides and
//   compares species one at a time (straight to decide with no species in use).
// Throughput: one request at a time on the shared multiplier and single memory
//   read port; a new request is taken while the previous response waits.
// Reset: synchronous; species_in_use returns to 8, the memory is not cleared.
// ----------------------------------------------------------------------------
// neighbor_colonization_select_top
// Roulette-wheel choice of the species that colonizes an empty cell.
// ----------------------------------------------------------------------------
module neighbor_colonization_select_top (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_we,
   input  logic [3:0] csr_wdata,
   ncs_req_if.sink   req_if,
   ncs_rsp_if.source rsp_if
);

   ncs_pkg::cmd_type    cmd;
   ncs_pkg::status_type status;

   ncs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ncs_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_habitat         (req_if.habitat),
      .req_species_index   (req_if.species_index),
      .req_probability     (req_if.probability),
      .req_neighbor_counts (req_if.neighbor_counts),
      .req_rand_draw       (req_if.rand_draw),
      .cmd                 (cmd),
      .status              (status),
      .rsp_colonizer       (rsp_if.colonizer)
   );

endmodule
